[hdl/ftfc_pkg.sv]
package ftfc_pkg;

    localparam int BUCKETS      = 256;
    localparam int POOL_ENTRIES = 1024;
    localparam int COUNT_BITS   = 32;
    localparam int BKT_BITS     = $clog2(BUCKETS);
    localparam int IDX_BITS     = $clog2(POOL_ENTRIES);
    localparam int LINK_BITS    = $clog2(POOL_ENTRIES + 1);

    localparam logic [7:0]  PROTO_TCP = 8'h06;
    localparam logic [7:0]  PROTO_UDP = 8'h11;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } t_in;

    typedef struct packed {
        logic [31:0] flow_packets;
        logic        is_new_flow;
        logic        table_full;
        logic [31:0] total_packets;
        logic [10:0] distinct_flows;
    } t_out;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_HEAD_RD, ST_HEAD_WAIT, ST_ENT_RD,
        ST_ENT_WAIT, ST_CHECK, ST_WRITE, ST_OUT
    } t_state;

    // One CRC byte step: eight shift/xor stages on a 32-bit value.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hdl/ftfc_if.sv]
interface ftfc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/five_tuple_flow_counter_top.sv]
// Counts packets per IPv4 5-tuple flow in a hashed table with chained buckets.
// After reset the block clears its 256 bucket heads, one per cycle, and is not
// ready until the clear is done. Each accepted packet is then hashed, one CRC
// byte per cycle over its 13 key bytes, the bucket head is read (ST_HEAD_RD,
// ST_HEAD_WAIT) and every chain entry visited is read and compared (ST_ENT_RD,
// ST_ENT_WAIT, ST_CHECK). A hit goes straight to the result state; a miss ends
// the walk and inserts the entry in ST_WRITE, unless the pool is full, before the
// result state. Only one packet is in flight; the block is not ready until its
// result is taken.
module five_tuple_flow_counter_top (
    input  logic i_clk,
    input  logic i_rst_n,
    ftfc_if.sink   s_in,
    ftfc_if.source m_out
);
    import ftfc_pkg::*;

    t_state r_state, n_state;
    t_in    r_key;
    logic [103:0] r_bytes;
    logic [3:0]   r_cnt;
    logic [31:0]  r_crc;
    logic [BKT_BITS-1:0]  r_bkt;
    logic [LINK_BITS-1:0] r_cur, r_last, r_free;
    logic [10:0]  r_guard;
    logic [COUNT_BITS-1:0] r_pkts;
    logic [10:0]  r_flows;
    t_out         r_out;
    logic [BKT_BITS-1:0] r_clr;

    // memories
    logic                  head_we;
    logic [BKT_BITS-1:0]   head_wa, head_ra;
    logic [LINK_BITS-1:0]  head_wd, head_rd;
    logic                  ent_we, link_we, cnt_we;
    logic [IDX_BITS-1:0]   ent_wa, link_wa, cnt_wa, ent_ra;
    logic [103:0]          key_wd, key_rd;
    logic [LINK_BITS-1:0]  link_wd, link_rd;
    logic [COUNT_BITS-1:0] cnt_wd, cnt_rd;

    ftfc_ram #(.WIDTH(LINK_BITS), .DEPTH(BUCKETS)) u_head (
        .i_clk, .i_we(head_we), .i_waddr(head_wa), .i_wdata(head_wd),
        .i_raddr(head_ra), .o_rdata(head_rd));
    ftfc_ram #(.WIDTH(104), .DEPTH(POOL_ENTRIES)) u_key (
        .i_clk, .i_we(ent_we), .i_waddr(ent_wa), .i_wdata(key_wd),
        .i_raddr(ent_ra), .o_rdata(key_rd));
    ftfc_ram #(.WIDTH(COUNT_BITS), .DEPTH(POOL_ENTRIES)) u_cnt (
        .i_clk, .i_we(cnt_we), .i_waddr(cnt_wa), .i_wdata(cnt_wd),
        .i_raddr(ent_ra), .o_rdata(cnt_rd));

    logic walk_ok, match, do_ins, full_now;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic is_tcpudp;

    assign is_tcpudp = (s_in.data.ip_protocol == PROTO_TCP) ||
                       (s_in.data.ip_protocol == PROTO_UDP);
    assign walk_ok = (r_cur != '0) && (r_cur <= LINK_BITS'(POOL_ENTRIES)) &&
                     (r_guard < 11'(POOL_ENTRIES));
    assign match   = (key_rd == r_bytes);
    assign cnt_inc = (cnt_rd == COUNT_MAX) ? COUNT_MAX : cnt_rd + 1'b1;
    assign full_now = (r_free >= LINK_BITS'(POOL_ENTRIES));
    assign ent_ra  = IDX_BITS'(r_cur - 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:     if (r_clr == '1) n_state = ST_IDLE;
            ST_IDLE:      if (s_in.valid) n_state = ST_HASH;
            ST_HASH:      if (r_cnt == 4'd12) n_state = ST_HEAD_RD;
            ST_HEAD_RD:   n_state = ST_HEAD_WAIT;
            ST_HEAD_WAIT: n_state = ST_ENT_RD;
            ST_ENT_RD:    n_state = walk_ok ? ST_ENT_WAIT : ST_WRITE;
            ST_ENT_WAIT:  n_state = ST_CHECK;
            ST_CHECK:     n_state = match ? ST_OUT : ST_ENT_RD;
            ST_WRITE:     n_state = ST_OUT;
            ST_OUT:       if (m_out.ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        s_in.ready  = (r_state == ST_IDLE);
        m_out.valid = (r_state == ST_OUT);
        m_out.data  = r_out;
        head_ra = r_bkt;
        head_we = 1'b0;
        head_wa = r_bkt;
        head_wd = LINK_BITS'(r_free + 1'b1);
        ent_we  = 1'b0;
        ent_wa  = IDX_BITS'(r_free);
        key_wd  = r_bytes;
        link_we = 1'b0;
        link_wa = IDX_BITS'(r_last - 1'b1);
        link_wd = LINK_BITS'(r_free + 1'b1);
        cnt_we  = 1'b0;
        cnt_wa  = ent_ra;
        cnt_wd  = cnt_inc;
        do_ins  = (r_state == ST_WRITE) && !full_now;
        case (r_state)
            ST_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_clr;
                head_wd = '0;
            end
            ST_CHECK: cnt_we = match;
            ST_WRITE: begin
                if (do_ins) begin
                    ent_we  = 1'b1;
                    cnt_we  = 1'b1;
                    cnt_wa  = IDX_BITS'(r_free);
                    cnt_wd  = COUNT_BITS'(1);
                    head_we = (r_last == '0);
                    link_we = (r_last != '0);
                end
            end
            default: ;
        endcase
    end

    // The new entry's own link is written in the cycle after insertion.
    logic r_link_clr;
    logic [IDX_BITS-1:0] r_link_clr_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_pkts  <= '0;
            r_flows <= '0;
            r_free  <= '0;
            r_link_clr <= 1'b0;
        end else begin
            r_state <= n_state;
            r_link_clr <= do_ins;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == ST_IDLE && s_in.valid) begin
                r_pkts <= (r_pkts == COUNT_MAX) ? COUNT_MAX : r_pkts + 1'b1;
            end
            if (do_ins) begin
                r_free  <= r_free + 1'b1;
                r_flows <= r_flows + 1'b1;
            end
        end
    end

    // Link clear shares the link port; the walk never uses it in that cycle.
    logic [LINK_BITS-1:0] link_wd_f;
    assign link_wd_f = '0;

    always_ff @(posedge i_clk) begin
        r_link_clr_a <= IDX_BITS'(r_free);
        case (r_state)
            ST_IDLE: begin
                r_bytes <= {s_in.data.source_address, s_in.data.dest_address,
                            is_tcpudp ? s_in.data.source_port : 16'd0,
                            is_tcpudp ? s_in.data.dest_port : 16'd0,
                            s_in.data.ip_protocol};
                r_crc   <= '1;
                r_cnt   <= '0;
                r_guard <= '0;
                r_last  <= '0;
            end
            ST_HASH: begin
                r_crc <= crc_byte(r_crc, r_bytes[103 - 8*r_cnt -: 8]);
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 4'd12) begin
                    r_bkt <= BKT_BITS'(~crc_byte(r_crc, r_bytes[103 - 8*r_cnt -: 8]));
                end
            end
            ST_HEAD_WAIT: r_cur <= head_rd;
            ST_ENT_RD: if (!walk_ok) r_out.flow_packets <= '0;
            ST_CHECK: begin
                if (match) begin
                    r_out.flow_packets <= 32'(cnt_inc);
                    r_out.is_new_flow  <= 1'b0;
                    r_out.table_full   <= 1'b0;
                end else begin
                    r_last  <= r_cur;
                    r_cur   <= link_rd;
                    r_guard <= r_guard + 1'b1;
                end
                r_out.total_packets  <= 32'(r_pkts);
                r_out.distinct_flows <= r_flows;
            end
            ST_WRITE: begin
                r_out.flow_packets   <= full_now ? 32'd0 : 32'd1;
                r_out.is_new_flow    <= !full_now;
                r_out.table_full     <= full_now;
                r_out.total_packets  <= 32'(r_pkts);
                r_out.distinct_flows <= full_now ? r_flows : r_flows + 1'b1;
            end
            default: ;
        endcase
    end

    // Terminate the freshly written entry's chain link in the cycle after the
    // insertion (ST_OUT never reads the link memory).
    logic [IDX_BITS-1:0] link_wa_m;
    logic [LINK_BITS-1:0] link_wd_m;
    logic link_we_m;
    assign link_we_m = link_we || r_link_clr;
    assign link_wa_m = r_link_clr ? r_link_clr_a : link_wa;
    assign link_wd_m = r_link_clr ? link_wd_f : link_wd;

    ftfc_ram #(.WIDTH(LINK_BITS), .DEPTH(POOL_ENTRIES)) u_link (
        .i_clk, .i_we(link_we_m), .i_waddr(link_wa_m), .i_wdata(link_wd_m),
        .i_raddr(ent_ra), .o_rdata(link_rd));

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> !s_in.ready) else $error("busy while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flows <= 11'(POOL_ENTRIES)) else $error("flow count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.data.is_new_flow) |-> !m_out.data.table_full)
        else $error("new and full together");
endmodule

[hdl/ftfc_ram.sv]
module ftfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[dv/tb.sv]
module tb;
    import ftfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_PACKETS = 1730;

    typedef struct {
        t_in  pkt;
        bit   typed;
        t_out result;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    ftfc_if #(.T(t_in))  in_ch ();
    ftfc_if #(.T(t_out)) out_ch ();

    five_tuple_flow_counter_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch),
        .m_out   (out_ch)
    );

    // Flow table as seen from outside: count per normalized 5-tuple key.
    int unsigned    flow_count[bit [103:0]];
    logic [32:0]    packet_total;
    int unsigned    flows_allocated;
    t_out           pending_results[$];
    t_in            known_flows[$];
    int             error_count;
    int             idle_cycles;
    bit             calm;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit [103:0] flow_key(input t_in p);
        logic [15:0] sp;
        logic [15:0] dp;
        sp = '0;
        dp = '0;
        if (p.ip_protocol == PROTO_TCP || p.ip_protocol == PROTO_UDP) begin
            sp = p.source_port;
            dp = p.dest_port;
        end
        return {p.source_address, p.dest_address, sp, dp, p.ip_protocol};
    endfunction

    // Updates the flow table with one packet and returns the block's report.
    function automatic t_out count_packet(input t_in p);
        t_out        r;
        bit [103:0]  k;
        k = flow_key(p);
        r = '0;
        if (packet_total < 33'hFFFF_FFFF) packet_total = packet_total + 1;
        if (flow_count.exists(k)) begin
            if (flow_count[k] != 32'hFFFF_FFFF) flow_count[k] = flow_count[k] + 1;
            r.flow_packets = flow_count[k];
        end else if (flows_allocated >= POOL_ENTRIES) begin
            r.table_full = 1'b1;
        end else begin
            flow_count[k] = 1;
            flows_allocated++;
            r.flow_packets = 32'd1;
            r.is_new_flow  = 1'b1;
        end
        r.total_packets  = packet_total[31:0];
        r.distinct_flows = flows_allocated[10:0];
        return r;
    endfunction

    function automatic int draw_gap();
        if (calm || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic t_in random_packet();
        t_in p;
        int  sel;
        p.source_address = $urandom;
        p.dest_address   = $urandom;
        p.source_port    = $urandom_range(0, 65535);
        p.dest_port      = $urandom_range(0, 65535);
        sel = $urandom_range(0, 9);
        if (sel < 4)      p.ip_protocol = PROTO_TCP;
        else if (sel < 8) p.ip_protocol = PROTO_UDP;
        else              p.ip_protocol = $urandom_range(0, 255);
        return p;
    endfunction

    // Presents one packet, waits for its transaction and records the expectation.
    task automatic send_packet(input t_in p, input bit typed, input t_out typed_result);
        int   gap;
        t_out predicted;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= p;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = count_packet(p);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // Result side: random back-pressure per transaction.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            stall_left   <= draw_gap();
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out exp_r;
        t_out got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.flow_packets !== exp_r.flow_packets) begin
                    $display("%0t: flow_packets expected %0d got %0d",
                             $time, exp_r.flow_packets, got.flow_packets);
                    error_count++;
                end
                if (got.is_new_flow !== exp_r.is_new_flow) begin
                    $display("%0t: is_new_flow expected %0b got %0b",
                             $time, exp_r.is_new_flow, got.is_new_flow);
                    error_count++;
                end
                if (got.table_full !== exp_r.table_full) begin
                    $display("%0t: table_full expected %0b got %0b",
                             $time, exp_r.table_full, got.table_full);
                    error_count++;
                end
                if (got.total_packets !== exp_r.total_packets) begin
                    $display("%0t: total_packets expected %0d got %0d",
                             $time, exp_r.total_packets, got.total_packets);
                    error_count++;
                end
                if (got.distinct_flows !== exp_r.distinct_flows) begin
                    $display("%0t: distinct_flows expected %0d got %0d",
                             $time, exp_r.distinct_flows, got.distinct_flows);
                    error_count++;
                end
            end
        end
    end

    // The bucket clear after reset lies well inside the limit.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        t_in  p;
        t_out none;

        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        error_count  = 0;
        packet_total = '0;
        flows_allocated = 0;
        calm = 1'b0;
        none = '0;

        // All-zero TCP packet right after reset: first flow, first packet.
        row.pkt = '{PROTO_TCP, 32'h0, 32'h0, 16'h0, 16'h0};
        row.typed = 1'b1;
        row.result = '{32'd1, 1'b1, 1'b0, 32'd1, 11'd1};
        rows.push_back(row);
        row.result = '{32'd2, 1'b0, 1'b0, 32'd2, 11'd1};
        rows.push_back(row);
        // All-ones addresses and ports with a protocol that ignores ports.
        row.pkt = '{8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF};
        row.result = '{32'd1, 1'b1, 1'b0, 32'd3, 11'd2};
        rows.push_back(row);
        // Same flow again with other port values, which must not matter.
        row.pkt = '{8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h1234, 16'h0000};
        row.result = '{32'd2, 1'b0, 1'b0, 32'd4, 11'd2};
        rows.push_back(row);
        row.typed = 1'b0;
        row.result = none;
        row.pkt = '{PROTO_UDP, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0};
        rows.push_back(row);
        row.pkt = '{PROTO_UDP, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h1};
        rows.push_back(row);
        row.pkt = '{PROTO_TCP, 32'h0, 32'h0, 16'h0, 16'h0};
        rows.push_back(row);
        row.pkt = '{8'h00, 32'hC0A8_0001, 32'h0A00_0001, 16'hAAAA, 16'h5555};
        rows.push_back(row);
        row.pkt = '{8'h00, 32'hC0A8_0001, 32'h0A00_0001, 16'h5555, 16'hAAAA};
        rows.push_back(row);
        row.pkt = '{PROTO_TCP, 32'hC0A8_0001, 32'h0A00_0001, 16'd80, 16'd443};
        rows.push_back(row);
        row.pkt = '{PROTO_TCP, 32'h0A00_0001, 32'hC0A8_0001, 16'd443, 16'd80};
        rows.push_back(row);
        row.pkt = '{PROTO_TCP, 32'hC0A8_0001, 32'h0A00_0001, 16'd80, 16'd443};
        rows.push_back(row);
        row.pkt = '{8'h01, 32'h8000_0000, 32'h0000_0001, 16'h0, 16'h0};
        rows.push_back(row);
        row.pkt = '{8'h11, 32'h0000_0001, 32'h8000_0000, 16'h8000, 16'h0001};
        rows.push_back(row);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_packet(rows[i].pkt, rows[i].typed, rows[i].result);
            known_flows.push_back(rows[i].pkt);
        end

        // Roughly two thirds new flows, so the pool fills partway through the run
        // and later unknown flows must be refused while known ones keep counting.
        for (int n = 0; n < RANDOM_PACKETS; n++) begin
            if (n % 200 == 0) calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 35) begin
                p = known_flows[$urandom_range(0, known_flows.size() - 1)];
                if (p.ip_protocol != PROTO_TCP && p.ip_protocol != PROTO_UDP) begin
                    p.source_port = $urandom_range(0, 65535);
                    p.dest_port   = $urandom_range(0, 65535);
                end
            end else begin
                p = random_packet();
                known_flows.push_back(p);
            end
            send_packet(p, 1'b0, none);
        end
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
hdl/ftfc_pkg.sv
hdl/ftfc_if.sv
hdl/ftfc_ram.sv
hdl/five_tuple_flow_counter_top.sv
dv/tb.sv
